// File: rtl/hce_pkg.sv
// Shared types and constants for the mod-26 Hill cipher encryptor.
`timescale 1ns / 1ps

package hce_pkg;

   localparam int unsigned ENTRY_W     = 5;
   localparam int unsigned KEY_W       = 20;
   localparam int unsigned KEY_ROWS    = 4;
   localparam int unsigned DIM_W       = 3;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned TEXT_W      = 8;
   localparam int unsigned CHAR_W      = 7;

   localparam logic [ENTRY_W-1:0] ALPHA       = 5'd26;
   localparam logic [ENTRY_W-1:0] PAD_LETTER  = 5'd23;
   localparam logic [ENTRY_W-1:0] LETTER_N    = 5'd13;
   localparam logic [TEXT_W-1:0]  N_TILDE_LEAD = 8'hC3;
   localparam logic [TEXT_W-1:0]  ASCII_A     = 8'd65;
   localparam logic [TEXT_W-1:0]  ASCII_Z     = 8'd90;
   localparam logic [DIM_W-1:0]   DIM_RESET   = 3'd2;

   // floor(2^18 / 26): quotient estimate is low by at most one below 21845
   localparam int unsigned RECIP_W     = 14;
   localparam logic [RECIP_W-1:0] RECIP_MUL = 14'd10082;
   localparam int unsigned RECIP_SHIFT = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_DIM = 3'd0,
      CSR_KEY_ROW0  = 3'd1,
      CSR_KEY_ROW1  = 3'd2,
      CSR_KEY_ROW2  = 3'd3,
      CSR_KEY_ROW3  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic [TEXT_W-1:0] text_byte;
      logic              end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cipher_char;
      logic              block_last;
   } rsp_payload_type;

   typedef struct packed {
      logic accept;
      logic mac;
      logic load_row;
   } cmd_type;

   typedef struct packed {
      logic block_ready;
      logic last_col;
      logic last_row;
      logic out_free;
   } status_type;

endpackage

// File: rtl/hill_cipher_encryptor_unit.sv
// Top level of the mod-26 Hill cipher encryptor: controller plus datapath.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_payload (text_byte, end_of_text)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_payload (cipher_char, block_last)
//   csr     | in        | csr_write_enable    | csr_index, csr_write_data
//
// A byte that does not complete a block is taken in ST_IDLE with no stall; input is taken every cycle while idle.
// A transaction that completes a block of d letters holds req_stall high while, for
// each row, ST_MAC accumulates the d products on the single 5x5 multiplier and
// ST_LOAD reduces the row mod 26 into the output register, waiting while
// rsp_stall backs up the output register. The last letter may still wait in the
// output register while the next transaction is taken. Reset is synchronous.
`timescale 1ns / 1ps

module hill_cipher_encryptor_unit
   import hce_pkg::*;
#(
   parameter int unsigned MAX_DIM = 4
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_write_data
);

   cmd_type    cmd;
   status_type status;

   hce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   hce_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload)
   );

endmodule

// File: rtl/hce_ctrl.sv
// Controller state machine: input acceptance, row/column sequencing, result loading.
`timescale 1ns / 1ps

module hce_ctrl
   import hce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output logic       req_stall,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.block_ready) begin
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cmd.mac = 1'b1;
            if (status.last_col) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.load_row = 1'b1;
               state_in = status.last_row ? ST_IDLE : ST_MAC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/hce_datapath.sv
// Datapath: registers, letter buffer, multiply-accumulate and mod-26 output stage.
`timescale 1ns / 1ps

module hce_datapath
   import hce_pkg::*;
#(
   parameter int unsigned MAX_DIM = 4
)(
   input  logic                 clock,
   input  logic                 reset,
   input  req_payload_type      req_payload,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_write_data,
   input  logic                 rsp_stall,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   output rsp_payload_type      rsp_payload
);

   localparam int unsigned IDXW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int unsigned DW   = $clog2(MAX_DIM + 1);
   localparam int unsigned ACCW = $clog2(MAX_DIM * 625 + 1);
   localparam int unsigned QPW  = ACCW + RECIP_W;

   logic [DIM_W-1:0]   dim_ff;
   logic [KEY_W-1:0]   key_ff [KEY_ROWS];
   logic [ENTRY_W-1:0] buf_ff [MAX_DIM];
   logic [DW-1:0]      count_ff, count_in;
   logic [DW-1:0]      fill_ff,  fill_in;
   logic [IDXW-1:0]    row_ff,   row_in;
   logic [IDXW-1:0]    col_ff,   col_in;
   logic [ACCW-1:0]    acc_ff,   acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   logic [DW-1:0]      dim_eff;
   logic [DW-1:0]      count_eff;
   logic [DW-1:0]      count_inc;
   logic               is_letter;
   logic [ENTRY_W-1:0] letter;
   logic               write_letter;
   logic [ENTRY_W-1:0] col_letter;
   logic [1:0]         key_row_sel;
   logic [1:0]         key_col_sel;
   logic [KEY_W-1:0]   key_row;
   logic [ENTRY_W-1:0] key_raw;
   logic [ENTRY_W-1:0] key_mod;
   logic [2*ENTRY_W-1:0] prod;
   logic [QPW-1:0]     q_prod;
   logic [ACCW-1:0]    quot;
   logic [ACCW-1:0]    rem_raw;
   logic [ENTRY_W-1:0] rem_mod;

   // effective dimension: zero acts as one, anything above MAX_DIM as MAX_DIM
   always_comb begin
      if (dim_ff == '0) begin
         dim_eff = DW'(1);
      end else if (32'(dim_ff) > MAX_DIM) begin
         dim_eff = DW'(MAX_DIM);
      end else begin
         dim_eff = DW'(dim_ff);
      end
   end

   assign count_eff = (count_ff >= dim_eff) ? '0 : count_ff;
   assign count_inc = count_eff + DW'(1);

   always_comb begin
      is_letter = 1'b0;
      letter    = '0;
      if (req_payload.text_byte == N_TILDE_LEAD) begin
         is_letter = 1'b1;
         letter    = LETTER_N;
      end else if (req_payload.text_byte >= ASCII_A && req_payload.text_byte <= ASCII_Z) begin
         is_letter = 1'b1;
         letter    = ENTRY_W'(req_payload.text_byte - ASCII_A);
      end
   end

   assign write_letter = cmd.accept && !req_payload.end_of_text && is_letter;

   assign status.block_ready = req_payload.end_of_text ? (count_eff != '0)
                                                       : (is_letter && count_inc == dim_eff);
   assign status.last_col = (DW'(col_ff) == dim_eff - DW'(1));
   assign status.last_row = (DW'(row_ff) == dim_eff - DW'(1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // column operand, padded with X past the real letters
   assign col_letter = (DW'(col_ff) < fill_ff) ? buf_ff[col_ff] : PAD_LETTER;

   // key entries outside the four register rows and columns read as zero
   assign key_row_sel = 2'(row_ff);
   assign key_col_sel = 2'(col_ff);
   assign key_row     = key_ff[key_row_sel];
   assign key_raw     = key_row[ENTRY_W*key_col_sel +: ENTRY_W];

   always_comb begin
      if (32'(row_ff) >= KEY_ROWS || 32'(col_ff) >= KEY_ROWS) begin
         key_mod = '0;
      end else if (key_raw >= ALPHA) begin
         key_mod = key_raw - ALPHA;
      end else begin
         key_mod = key_raw;
      end
   end

   assign prod = key_mod * col_letter;

   // acc mod 26 by reciprocal multiply and one correction step
   assign q_prod  = QPW'(acc_ff) * QPW'(RECIP_MUL);
   assign quot    = ACCW'(q_prod >> RECIP_SHIFT);
   assign rem_raw = acc_ff - ((quot << 4) + (quot << 3) + (quot << 1));
   assign rem_mod = (rem_raw >= ACCW'(ALPHA)) ? ENTRY_W'(rem_raw - ACCW'(ALPHA))
                                              : ENTRY_W'(rem_raw);

   always_comb begin
      count_in     = count_ff;
      fill_in      = fill_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      acc_in       = acc_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.accept) begin
         row_in = '0;
         col_in = '0;
         acc_in = '0;
         if (req_payload.end_of_text) begin
            if (count_eff != '0) begin
               fill_in  = count_eff;
               count_in = '0;
            end else begin
               count_in = count_eff;
            end
         end else if (is_letter) begin
            if (count_inc == dim_eff) begin
               fill_in  = count_inc;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end else begin
            count_in = count_eff;
         end
      end

      if (cmd.mac) begin
         acc_in = acc_ff + ACCW'(prod);
         col_in = col_ff + IDXW'(1);
      end

      if (cmd.load_row) begin
         char_in      = CHAR_W'(ASCII_A) + CHAR_W'(rem_mod);
         last_in      = status.last_row;
         rsp_valid_in = 1'b1;
         row_in       = row_ff + IDXW'(1);
         col_in       = '0;
         acc_in       = '0;
      end

      // a new dimension drops the partial block
      if (csr_write_enable && csr_index == CSR_BLOCK_DIM) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= DIM_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KEY_ROWS; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_BLOCK_DIM: dim_ff    <= csr_write_data[DIM_W-1:0];
               CSR_KEY_ROW0:  key_ff[0] <= csr_write_data;
               CSR_KEY_ROW1:  key_ff[1] <= csr_write_data;
               CSR_KEY_ROW2:  key_ff[2] <= csr_write_data;
               CSR_KEY_ROW3:  key_ff[3] <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      fill_ff <= fill_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      acc_ff  <= acc_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (write_letter) begin
         buf_ff[count_eff[IDXW-1:0]] <= letter;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_payload.cipher_char = char_ff;
   assign rsp_payload.block_last  = last_ff;

endmodule

// File: rtl/hce_checker.sv
// Port-level assertions for the Hill cipher encryptor, bound to the top level.
`timescale 1ns / 1ps

module hce_checker
   import hce_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   logic drop_byte;

   assign drop_byte = !req_payload.end_of_text &&
                      req_payload.text_byte != N_TILDE_LEAD &&
                      (req_payload.text_byte < ASCII_A || req_payload.text_byte > ASCII_Z);

   // reset empties the output register
   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // held result stays put while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.cipher_char >= 7'd65 && rsp_payload.cipher_char <= 7'd90))
      else $error("cipher letter outside A to Z");

   // rows of a block are still being worked on after a non-final letter leaves
   a_block_in_progress: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.block_last |-> req_stall)
      else $error("input taken in the middle of a block");

   // a dropped byte never holds off the next transaction
   a_drop_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && drop_byte |=> !req_stall)
      else $error("dropped byte caused a stall");

endmodule

bind hill_cipher_encryptor_unit hce_checker u_hce_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// File: verif/hill_cipher_encryptor_unit_tb.sv
// Self-checking testbench for the mod-26 Hill cipher encryptor unit.
`timescale 1ns / 1ps

module hill_cipher_encryptor_unit_tb
   import hce_pkg::*;
;

   localparam int unsigned DIM_LIMIT     = 4;
   localparam int unsigned SETTLE_CYCLES = 30;
   localparam int unsigned PHASES        = 9;
   localparam int unsigned PER_PHASE     = 27;

   // Tracks the cipher state and holds the letters the block must return.
   class cipher_scoreboard;
      logic [DIM_W-1:0]   dim_reg;
      logic [KEY_W-1:0]   key_row [KEY_ROWS];
      logic [ENTRY_W-1:0] letters [DIM_LIMIT];
      int unsigned        count;
      rsp_payload_type    expected_letters [$];
      int unsigned        failures, checked, blocks, padded, kept, dropped, empty_flush;

      function new();
         dim_reg = DIM_RESET;
         foreach (key_row[r]) key_row[r] = '0;
         foreach (letters[i]) letters[i] = '0;
         count = 0;
         failures = 0;
         checked = 0;
         blocks = 0;
         padded = 0;
         kept = 0;
         dropped = 0;
         empty_flush = 0;
      endfunction

      function int unsigned pending();
         return expected_letters.size();
      endfunction

      function void take_register(csr_index_type idx, logic [KEY_W-1:0] data);
         case (idx)
            CSR_BLOCK_DIM: begin
               dim_reg = data[DIM_W-1:0];
               count   = 0;
            end
            CSR_KEY_ROW0: key_row[0] = data;
            CSR_KEY_ROW1: key_row[1] = data;
            CSR_KEY_ROW2: key_row[2] = data;
            CSR_KEY_ROW3: key_row[3] = data;
            default: ;
         endcase
      endfunction

      // c = K * p mod 26, one letter per key row
      function void encrypt_block(int unsigned d);
         int unsigned     acc;
         rsp_payload_type letter_out;
         for (int unsigned r = 0; r < d; r++) begin
            acc = 0;
            for (int unsigned c = 0; c < d; c++)
               acc += (int'(key_row[r][c*ENTRY_W +: ENTRY_W]) % ALPHA) * letters[c];
            letter_out.cipher_char = CHAR_W'(ASCII_A + acc % ALPHA);
            letter_out.block_last  = (r + 1 == d);
            expected_letters.push_back(letter_out);
         end
         blocks++;
         count = 0;
      endfunction

      function void take_text(req_payload_type item);
         int unsigned        d;
         logic [ENTRY_W-1:0] letter;
         d = (dim_reg == 0) ? 1 : ((dim_reg > DIM_LIMIT) ? DIM_LIMIT : dim_reg);
         if (count >= d) count = 0;
         if (item.end_of_text) begin
            if (count == 0) begin
               empty_flush++;
               return;
            end
            for (int unsigned i = count; i < d; i++) letters[i] = PAD_LETTER;
            padded++;
            encrypt_block(d);
            return;
         end
         if (item.text_byte == N_TILDE_LEAD)
            letter = LETTER_N;
         else if (item.text_byte >= ASCII_A && item.text_byte <= ASCII_Z)
            letter = ENTRY_W'(item.text_byte - ASCII_A);
         else begin
            dropped++;
            return;
         end
         kept++;
         letters[count % DIM_LIMIT] = letter;
         count++;
         if (count >= d) encrypt_block(d);
      endfunction

      function void compare_letter(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_letters.size() == 0) begin
            $error("cipher_char: nothing expected, got %0d (block_last %0b)",
                   got.cipher_char, got.block_last);
            failures++;
            return;
         end
         want = expected_letters.pop_front();
         checked++;
         if (got.cipher_char !== want.cipher_char) begin
            $error("cipher_char: expected %0d, got %0d", want.cipher_char, got.cipher_char);
            failures++;
         end
         if (got.block_last !== want.block_last) begin
            $error("block_last: expected %0b, got %0b", want.block_last, got.block_last);
            failures++;
         end
      endfunction
   endclass

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload      = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [KEY_W-1:0]     csr_write_data   = '0;

   int unsigned          send_idle_pct    = 0;
   int unsigned          recv_stall_pct   = 0;
   cipher_scoreboard     sb;

   hill_cipher_encryptor_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("hill_cipher_encryptor_unit_tb NOT OK");
      $finish;
   end

   // Check each accepted letter, then pick the next stall value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.compare_letter(rsp_payload);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic req_payload_type text_of(logic [TEXT_W-1:0] b, logic eot);
      req_payload_type item;
      item.text_byte   = b;
      item.end_of_text = eot;
      return item;
   endfunction

   task automatic send_text(input req_payload_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      sb.take_text(item);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Drain results, then give the block time to finish any letter-only work.
   task automatic settle_block();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input logic [KEY_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.take_register(idx, data);
   endtask

   task automatic load_settings(input logic [DIM_W-1:0] dim,
                                input logic [KEY_ROWS-1:0][KEY_W-1:0] rows);
      put_csr(CSR_KEY_ROW0, rows[0]);
      put_csr(CSR_KEY_ROW1, rows[1]);
      put_csr(CSR_KEY_ROW2, rows[2]);
      put_csr(CSR_KEY_ROW3, rows[3]);
      put_csr(CSR_BLOCK_DIM, KEY_W'(dim));
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      req_payload_type                 opening [$];
      req_payload_type                 item;
      logic [KEY_ROWS-1:0][KEY_W-1:0]  rows;
      logic [DIM_W-1:0]                phase_dims [PHASES];
      int unsigned                     useful, hold_at, pick;

      sb = new();
      phase_dims = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6, 3'd4};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 35;
      recv_stall_pct = 83;

      // Key entries cover 0, 25, 26 and 31 (reduces to 5).
      rows[0] = 20'hFFFFF;
      rows[1] = {5'd1, 5'd25, 5'd0, 5'd26};
      rows[2] = {5'd30, 5'd3, 5'd27, 5'd7};
      rows[3] = {5'd9, 5'd9, 5'd9, 5'd9};
      load_settings(3'd3, rows);

      opening = '{
         text_of(8'h00, 1'b1),                                  // flush with nothing stored
         text_of("A", 1'b0), text_of("Z", 1'b0), text_of(8'hC3, 1'b0),
         text_of(" ", 1'b0), text_of(8'h00, 1'b0), text_of(8'hFF, 1'b0),
         text_of(8'h40, 1'b0), text_of(8'h5B, 1'b0), text_of("a", 1'b0),
         text_of(8'h91, 1'b0), text_of("z", 1'b0),
         text_of("M", 1'b0), text_of(8'hAA, 1'b1),              // pad two letters
         text_of("Q", 1'b0), text_of("B", 1'b0), text_of("C", 1'b1), // pad one
         text_of(8'hC3, 1'b1),                                  // byte ignored on flush
         text_of("H", 1'b0), text_of("I", 1'b0), text_of("L", 1'b0),
         text_of("Z", 1'b0), text_of("Z", 1'b0), text_of("Z", 1'b0),
         text_of("K", 1'b0)                                     // left behind for rewrite
      };
      foreach (opening[i]) send_text(opening[i]);
      settle_block();

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         if (phase < 3) begin
            send_idle_pct  = 35;
            recv_stall_pct = 83;
         end else if (phase < 6) begin
            send_idle_pct  = 83;
            recv_stall_pct = 35;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end

         for (int r = 0; r < KEY_ROWS; r++) begin
            pick = $urandom_range(9);
            if (phase == 1 || pick == 1) rows[r] = 20'hFFFFF;
            else if (pick == 0)          rows[r] = '0;
            else                         rows[r] = KEY_W'($urandom_range(20'hFFFFF));
         end
         load_settings(phase_dims[phase], rows);

         useful  = 0;
         hold_at = $urandom_range(5, PER_PHASE - 5);
         while (useful < PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 55)
               item = text_of(8'($urandom_range(ASCII_Z, ASCII_A)), 1'b0);
            else if (pick < 60)
               item = text_of(N_TILDE_LEAD, 1'b0);
            else if (pick < 68)
               item = text_of(8'($urandom_range(255)), 1'b1);
            else
               item = text_of(8'($urandom_range(255)), 1'b0);
            if (item.end_of_text || item.text_byte == N_TILDE_LEAD ||
                (item.text_byte >= ASCII_A && item.text_byte <= ASCII_Z))
               useful++;
            if (useful == hold_at) hold_until_drained();
            send_text(item);
         end
         settle_block();
      end

      $display("covered %0d cipher letters in %0d blocks (%0d padded, %0d empty flushes),",
               sb.checked, sb.blocks, sb.padded, sb.empty_flush);
      $display("from %0d kept and %0d dropped bytes over dimension settings 0 to 7",
               sb.kept, sb.dropped);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("hill_cipher_encryptor_unit_tb OK");
      else
         $display("hill_cipher_encryptor_unit_tb NOT OK");
      $finish;
   end

endmodule
